// ===== rtl/pls_pkg.sv =====
// Shared codes and control bundles for the positional list store.
`default_nettype none

package pls_pkg;

	// Request operation codes
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_APPEND     = 3'd1;
	localparam logic [2:0] MODE_INSERT     = 3'd2;
	localparam logic [2:0] MODE_REMOVE     = 3'd3;
	localparam logic [2:0] MODE_FIND       = 3'd4;
	localparam logic [2:0] MODE_READ       = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// Field widths of the stream payloads
	localparam int MODE_W  = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int STAT_W  = 2;
	localparam int FIDX_W  = 6;
	localparam int ECNT_W  = 7;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 48;

	// Controller to datapath commands
	typedef struct packed {
		logic        take;
		logic        rd;
		logic        wr_shift;
		logic        put;
		logic        idx_inc;
		logic        idx_dec;
		logic        cnt_inc;
		logic        cnt_dec;
		logic        grab_found;
		logic        grab_rd;
		logic        out_load;
		logic [1:0]  st;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [2:0]  mode;
		logic        full;
		logic        pos_bad;
		logic        idx_gt_at;
		logic        idx_nxt_lt;
		logic        idx_lt;
		logic        match;
		logic        out_busy;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/pls_ctrl.sv =====
// Sequencing state machine for the positional list store.
`default_nettype none

module pls_ctrl
	import pls_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DEC  = 6'b000010,
		S_RD   = 6'b000100,
		S_WR   = 6'b001000,
		S_PUT  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] st_q, st_d;

	assign s_tready = (state_q == S_IDLE);

	// Next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		st_d    = st_q;
		cmd.st  = st_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.mode)
					MODE_PUSH_FRONT, MODE_APPEND, MODE_INSERT: begin
						if (sts.full) begin
							st_d    = ST_FULL;
							state_d = S_DONE;
						end else if (sts.idx_gt_at) begin
							state_d = S_RD;
						end else begin
							state_d = S_PUT;
						end
					end
					MODE_REMOVE: begin
						if (sts.pos_bad) begin
							st_d    = ST_RANGE;
							state_d = S_DONE;
						end else if (sts.idx_nxt_lt) begin
							state_d = S_RD;
						end else begin
							cmd.cnt_dec = 1'b1;
							st_d        = ST_OK;
							state_d     = S_DONE;
						end
					end
					MODE_FIND: begin
						if (sts.idx_lt) begin
							state_d = S_RD;
						end else begin
							st_d    = ST_NOTFOUND;
							state_d = S_DONE;
						end
					end
					MODE_READ: begin
						if (sts.pos_bad) begin
							st_d    = ST_RANGE;
							state_d = S_DONE;
						end else begin
							state_d = S_RD;
						end
					end
					default: begin
						st_d    = ST_OK;
						state_d = S_DONE;
					end
				endcase
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				case (sts.mode)
					MODE_PUSH_FRONT, MODE_APPEND, MODE_INSERT: begin
						cmd.wr_shift = 1'b1;
						cmd.idx_dec  = 1'b1;
						state_d      = S_DEC;
					end
					MODE_REMOVE: begin
						cmd.wr_shift = 1'b1;
						cmd.idx_inc  = 1'b1;
						state_d      = S_DEC;
					end
					MODE_FIND: begin
						if (sts.match) begin
							cmd.grab_found = 1'b1;
							st_d           = ST_OK;
							state_d        = S_DONE;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_DEC;
						end
					end
					MODE_READ: begin
						cmd.grab_rd = 1'b1;
						st_d        = ST_OK;
						state_d     = S_DONE;
					end
					default: begin
						st_d    = ST_OK;
						state_d = S_DONE;
					end
				endcase
			end
			S_PUT: begin
				cmd.put     = 1'b1;
				cmd.cnt_inc = 1'b1;
				st_d        = ST_OK;
				state_d     = S_DONE;
			end
			S_DONE: begin
				// hold until the result register is free
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pls_dpath.sv =====
// Entry memory, index and count registers and result register.
`default_nettype none

module pls_dpath
	import pls_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic [MODE_W-1:0]  in_mode,
	input  wire logic [VALUE_W-1:0] in_value,
	input  wire logic [POS_W-1:0]   in_position,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [STAT_W-1:0]       out_status,
	output logic [FIDX_W-1:0]       out_found_index,
	output logic [VALUE_W-1:0]      out_read_value,
	output logic [ECNT_W-1:0]       out_entry_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int WW = (CW > POS_W) ? CW : POS_W;
	localparam int FW = (AW > FIDX_W) ? AW : FIDX_W;
	localparam int EW = (CW > ECNT_W) ? CW : ECNT_W;

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_s1;

	logic [MODE_W-1:0]  mode_q;
	logic [VALUE_W-1:0] val_q;
	logic [POS_W-1:0]   pos_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      at_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      found_q;
	logic [VALUE_W-1:0] rd_q;
	logic               out_valid_q;

	logic [WW-1:0] pos_w, count_w, in_pos_w;
	logic [CW:0]   idx_nxt;
	logic [AW-1:0] raddr, waddr;
	logic [FW-1:0] found_w;
	logic [EW-1:0] count_e;

	assign pos_w    = WW'(pos_q);
	assign in_pos_w = WW'(in_position);
	assign count_w  = WW'(count_q);
	assign idx_nxt  = {1'b0, idx_q} + (CW + 1)'(1);

	// Flags for the controller
	always_comb begin
		sts.mode       = mode_q;
		sts.full       = (count_q == CW'(DEPTH));
		sts.pos_bad    = (pos_w >= count_w);
		sts.idx_gt_at  = (idx_q > at_q);
		sts.idx_nxt_lt = (idx_nxt < {1'b0, count_q});
		sts.idx_lt     = (idx_q < count_q);
		sts.match      = (rdata_s1 == val_q);
		sts.out_busy   = out_valid_q & ~out_ready;
	end

	// Read address follows the direction of the move
	always_comb begin
		case (mode_q)
			MODE_PUSH_FRONT, MODE_APPEND, MODE_INSERT: raddr = AW'(idx_q - CW'(1));
			MODE_REMOVE: raddr = idx_nxt[AW-1:0];
			default:     raddr = idx_q[AW-1:0];
		endcase
	end

	assign waddr = idx_q[AW-1:0];

	// Entry memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_shift || cmd.put) begin
			mem[waddr] <= cmd.put ? val_q : rdata_s1;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Latch the request and set up the walk
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q  <= in_mode;
			val_q   <= in_value;
			pos_q   <= in_position;
			found_q <= '0;
			rd_q    <= '0;
			case (in_mode)
				MODE_PUSH_FRONT: begin
					idx_q <= count_q;
					at_q  <= '0;
				end
				MODE_APPEND: begin
					idx_q <= count_q;
					at_q  <= count_q;
				end
				MODE_INSERT: begin
					idx_q <= count_q;
					at_q  <= (in_pos_w < count_w) ? CW'(in_position) : count_q;
				end
				MODE_REMOVE, MODE_READ: begin
					idx_q <= CW'(in_position);
					at_q  <= '0;
				end
				default: begin
					idx_q <= '0;
					at_q  <= '0;
				end
			endcase
		end else begin
			if (cmd.idx_inc) begin
				idx_q <= idx_nxt[CW-1:0];
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.grab_found) begin
				found_q <= idx_q[AW-1:0];
			end
			if (cmd.grab_rd) begin
				rd_q <= rdata_s1;
			end
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign found_w = FW'(found_q);
	assign count_e = EW'(count_q);

	// Result register, held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status      <= cmd.st;
			out_found_index <= found_w[FIDX_W-1:0];
			out_read_value  <= rd_q;
			out_entry_count <= count_e[ECNT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_grow_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (count_q != CW'(DEPTH)))
		else $error("count grown while full");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_shift || cmd.put) |-> (idx_q < CW'(DEPTH)))
		else $error("memory write beyond depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire

// ===== rtl/positional_list_store.sv =====
// Ordered bounded list of signed words: one operation per request.
// Push and insert move each later entry up one slot before the put; remove moves each
// later entry down; read fetches one entry; find compares entries in order to a hit or the end;
// full, out-of-range and unused requests go straight to the result. A result not yet taken holds the next load.
// Throughput: one request at a time, the next accepted the cycle after the result loads.
// Reset: arst_n clears count, controller and result valid; entries are written before read.
`default_nettype none

module positional_list_store
	import pls_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [IN_W-1:0] s_tdata,  // mode[2:0], value[34:3], position[41:35]
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [OUT_W-1:0]     m_tdata   // status[1:0], found_index[7:2],
	                                       // read_value[39:8], entry_count[46:40]
);

	cmd_t cmd;
	sts_t sts;

	logic [STAT_W-1:0]  status;
	logic [FIDX_W-1:0]  found_index;
	logic [VALUE_W-1:0] read_value;
	logic [ECNT_W-1:0]  entry_count;

	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pls_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_mode         (s_tdata[2:0]),
		.in_value        (s_tdata[34:3]),
		.in_position     (s_tdata[41:35]),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_status      (status),
		.out_found_index (found_index),
		.out_read_value  (read_value),
		.out_entry_count (entry_count)
	);

	// Pack the result fields
	assign m_tdata = {1'b0, entry_count, read_value, found_index, status};

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the positional list store with a shadow list predictor.
`default_nettype none

module testbench
	import pls_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 250;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MODE_UNUSED_A = 6;
	localparam int MODE_UNUSED_B = 7;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FIDX_W-1:0]  found_index;
		logic [VALUE_W-1:0] read_value;
		logic [ECNT_W-1:0]  entry_count;
	} list_result_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	// Shadow copy of the list and the results it predicts
	logic signed [VALUE_W-1:0] shadow_words [DEPTH];
	int                        shadow_count;
	list_result_t              pending_results [$];

	bit sender_quiet;
	bit receiver_quiet;
	int hold_off_request;
	int error_count;
	int requests_sent;
	int results_checked;
	int mode_seen [8];
	int status_seen [4];
	int idle_cycles;

	positional_list_store #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Clock and power-on values
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
	end

	always #1 clk = ~clk;

	// Apply one request to the shadow list and return the result it must produce
	function automatic list_result_t apply_request(logic [MODE_W-1:0] mode,
			logic signed [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
		list_result_t r;
		int at;
		int p;
		p = int'(pos);
		r = '0;
		r.status = ST_OK;
		case (mode)
			MODE_PUSH_FRONT, MODE_APPEND, MODE_INSERT: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (mode == MODE_PUSH_FRONT) begin
						at = 0;
					end else if (mode == MODE_APPEND) begin
						at = shadow_count;
					end else begin
						at = (p < shadow_count) ? p : shadow_count;
					end
					// Shift later entries up to open the slot
					for (int i = shadow_count; i > at; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[at] = value;
					shadow_count++;
				end
			end
			MODE_REMOVE: begin
				if (p >= shadow_count) begin
					r.status = ST_RANGE;
				end else begin
					// Shift later entries down over the removed slot
					for (int i = p; i + 1 < shadow_count; i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_count--;
				end
			end
			MODE_FIND: begin
				r.status = ST_NOTFOUND;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_words[i] == value) begin
						r.status = ST_OK;
						r.found_index = FIDX_W'(i);
						break;
					end
				end
			end
			MODE_READ: begin
				if (p >= shadow_count)
					r.status = ST_RANGE;
				else
					r.read_value = shadow_words[p];
			end
			default: ;
		endcase
		r.entry_count = ECNT_W'(shadow_count);
		return r;
	endfunction

	// Offer one request, wait for acceptance, then queue its expected result
	task automatic send_request(input logic [MODE_W-1:0] mode,
			input logic signed [VALUE_W-1:0] value, input logic [POS_W-1:0] pos);
		int gap;
		list_result_t want;
		gap = sender_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-MODE_W-VALUE_W-POS_W){1'b0}}, pos, value, mode};
		do @(posedge clk); while (!s_tready);
		want = apply_request(mode, value, pos);
		pending_results = {pending_results, want};
		mode_seen[mode]++;
		status_seen[want.status]++;
		requests_sent++;
	endtask

	// Pick a stored value most of the time so finds hit
	function automatic logic signed [VALUE_W-1:0] pick_value(bit from_list);
		logic signed [VALUE_W-1:0] pool [8];
		pool = '{32'sh0, -32'sd1, 32'sh7fffffff, 32'sh80000000,
			32'sd1, 32'sh55555555, 32'shaaaaaaaa, 32'sd42};
		if (from_list && shadow_count > 0 && $urandom_range(0, 9) < 7)
			return shadow_words[$urandom_range(0, shadow_count - 1)];
		if ($urandom_range(0, 1) == 0)
			return pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return POS_W'($urandom_range(0, shadow_count));
		if (r == 8)
			return POS_W'($urandom_range(shadow_count, DEPTH));
		return POS_W'($urandom_range(0, 127));
	endfunction

	// Draw one request with a mode mix that grows or shrinks the list
	task automatic send_random_request(input bit grow);
		int r;
		logic [MODE_W-1:0] mode;
		r = $urandom_range(0, 99);
		if (grow) begin
			if (r < 25)      mode = MODE_PUSH_FRONT;
			else if (r < 50) mode = MODE_APPEND;
			else if (r < 65) mode = MODE_INSERT;
			else if (r < 75) mode = MODE_REMOVE;
			else if (r < 87) mode = MODE_FIND;
			else if (r < 97) mode = MODE_READ;
			else             mode = MODE_W'($urandom_range(MODE_UNUSED_A, MODE_UNUSED_B));
		end else begin
			if (r < 5)       mode = MODE_PUSH_FRONT;
			else if (r < 10) mode = MODE_APPEND;
			else if (r < 15) mode = MODE_INSERT;
			else if (r < 65) mode = MODE_REMOVE;
			else if (r < 80) mode = MODE_FIND;
			else if (r < 95) mode = MODE_READ;
			else             mode = MODE_W'($urandom_range(MODE_UNUSED_A, MODE_UNUSED_B));
		end
		send_request(mode, pick_value(mode == MODE_FIND), pick_position());
	endtask

	// Empty-list errors, field extremes, every operation and unused modes
	task automatic test_directed();
		send_request(MODE_READ, 32'sd0, 7'd0);
		send_request(MODE_REMOVE, 32'sd0, 7'd0);
		send_request(MODE_FIND, 32'sd0, 7'd0);
		send_request(MODE_APPEND, 32'sh7fffffff, 7'd0);
		send_request(MODE_PUSH_FRONT, 32'sh80000000, 7'd127);
		send_request(MODE_INSERT, 32'sd0, 7'd1);
		send_request(MODE_INSERT, -32'sd1, 7'd127);
		send_request(MODE_INSERT, 32'sh55555555, 7'd64);
		send_request(MODE_APPEND, 32'shaaaaaaaa, 7'd0);
		send_request(MODE_PUSH_FRONT, -32'sd1, 7'd0);
		send_request(MODE_FIND, -32'sd1, 7'd0);
		send_request(MODE_FIND, 32'sd12345, 7'd0);
		send_request(MODE_READ, 32'sd0, 7'd0);
		send_request(MODE_READ, 32'sd0, POS_W'(shadow_count - 1));
		send_request(MODE_READ, 32'sd0, POS_W'(shadow_count));
		send_request(MODE_READ, 32'sd0, 7'd127);
		send_request(MODE_REMOVE, 32'sd0, 7'd3);
		send_request(MODE_REMOVE, 32'sd0, 7'd127);
		send_request(MODE_REMOVE, 32'sd0, 7'd0);
		send_request(MODE_REMOVE, 32'sd0, POS_W'(shadow_count - 1));
		send_request(MODE_W'(MODE_UNUSED_A), $urandom, POS_W'($urandom_range(0, 127)));
		send_request(MODE_W'(MODE_UNUSED_B), $urandom, POS_W'($urandom_range(0, 127)));
		send_request(MODE_FIND, 32'sh7fffffff, 7'd0);
		send_request(MODE_INSERT, 32'sd1, 7'd0);
	endtask

	// Fill to capacity, then hit the full store and the deepest scans
	task automatic test_full_store();
		logic signed [VALUE_W-1:0] last_word;
		while (shadow_count < DEPTH)
			send_request(MODE_APPEND, $urandom, POS_W'($urandom_range(0, 127)));
		last_word = shadow_words[DEPTH-1];
		send_request(MODE_PUSH_FRONT, 32'sd7, 7'd0);
		send_request(MODE_APPEND, 32'sd7, 7'd0);
		send_request(MODE_INSERT, 32'sd7, 7'd5);
		send_request(MODE_INSERT, 32'sd7, 7'd127);
		send_request(MODE_FIND, last_word, 7'd0);
		send_request(MODE_FIND, 32'sd12345, 7'd0);
		send_request(MODE_READ, 32'sd0, 7'd63);
		send_request(MODE_READ, 32'sd0, 7'd64);
		send_request(MODE_REMOVE, 32'sd0, 7'd63);
		send_request(MODE_PUSH_FRONT, -32'sd1, 7'd0);
		send_request(MODE_REMOVE, 32'sd0, 7'd0);
	endtask

	// Alternate growing and shrinking stretches with random content
	task automatic test_random_mix(input int n_requests);
		int left;
		int stretch;
		bit grow;
		left = n_requests;
		grow = 1'b0;
		while (left > 0) begin
			stretch = $urandom_range(30, 90);
			if (stretch > left)
				stretch = left;
			repeat (stretch) send_random_request(grow);
			left -= stretch;
			grow = !grow;
		end
	endtask

	// Hold the result side off while requests keep coming
	task automatic test_backpressure(input int n_requests);
		hold_off_request = HOLD_OFF_CYCLES;
		sender_quiet = 1'b1;
		repeat (n_requests) send_random_request($urandom_range(0, 1));
		sender_quiet = 1'b0;
	endtask

	// Run back to back with neither side idling
	task automatic test_full_rate(input int n_requests);
		sender_quiet = 1'b1;
		receiver_quiet = 1'b1;
		repeat (n_requests) send_random_request($urandom_range(0, 1));
		sender_quiet = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	// Remove at random positions until empty, then remove and read once more
	task automatic test_drain();
		while (shadow_count > 0)
			send_request(MODE_REMOVE, $urandom, POS_W'($urandom_range(0, shadow_count - 1)));
		send_request(MODE_REMOVE, 32'sd0, 7'd0);
		send_request(MODE_READ, 32'sd0, 7'd0);
	endtask

	// Sequence the tests and report
	initial begin
		shadow_count = 0;
		sender_quiet = 1'b0;
		receiver_quiet = 1'b0;
		hold_off_request = 0;
		error_count = 0;
		requests_sent = 0;
		results_checked = 0;
		foreach (mode_seen[i]) mode_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_store();
		test_random_mix(600);
		test_backpressure(30);
		test_full_rate(100);
		test_drain();
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests, %0d results checked, %0d mismatches.",
			requests_sent, results_checked, error_count);
		$display("Modes front/back/insert/remove/find/read/unused: %0d/%0d/%0d/%0d/%0d/%0d/%0d;%s%0d full, %0d range, %0d not found.",
			mode_seen[MODE_PUSH_FRONT], mode_seen[MODE_APPEND], mode_seen[MODE_INSERT],
			mode_seen[MODE_REMOVE], mode_seen[MODE_FIND], mode_seen[MODE_READ],
			mode_seen[MODE_UNUSED_A] + mode_seen[MODE_UNUSED_B], " ",
			status_seen[ST_FULL], status_seen[ST_RANGE], status_seen[ST_NOTFOUND]);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side: random stalls, optional long hold-off
	initial begin : result_sink
		int stall;
		int hold;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_request > 0) begin
				hold = hold_off_request;
				hold_off_request = 0;
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			stall = receiver_quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		list_result_t want;
		list_result_t got;
		if (m_tvalid && m_tready) begin
			got = list_result_t'({m_tdata[1:0], m_tdata[7:2], m_tdata[39:8], m_tdata[46:40]});
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: %h", m_tdata);
				error_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				results_checked++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					error_count++;
				end
				if (got.found_index !== want.found_index) begin
					$error("found_index: expected %0d, got %0d",
						want.found_index, got.found_index);
					error_count++;
				end
				if (got.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d",
						$signed(want.read_value), $signed(got.read_value));
					error_count++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, got.entry_count);
					error_count++;
				end
			end
		end
	end

	// Abort when no request or result moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
